@@ hw/rtl/nht_pkg.sv @@
// Node health table: shared widths, item codes, status codes and the queued command type.
// No dependencies; imported by every module of the block except nht_ram.
`default_nettype none

package nht_pkg;

  localparam int KIND_W    = 3;
  localparam int IDX_W     = 4;
  localparam int NOW_W     = 32;
  localparam int LOAD_W    = 10;
  localparam int TASK_W    = 16;
  localparam int TIMEOUT_W = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH    = 2;

  localparam logic [KIND_W-1:0] KIND_REG    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UNREG  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BEAT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REPORT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SWEEP  = 3'd5;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OVER = 2'd1;
  localparam logic [1:0] ST_DOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK    = 2'd3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 31'd30000;
  localparam logic [LOAD_W-1:0]    CPU_RST     = 10'd800;
  localparam logic [LOAD_W-1:0]    MEM_RST     = 10'd800;
  localparam logic [TASK_W-1:0]    TASK_RST    = 16'd100;
  localparam logic [LOAD_W-1:0]    LOAD_MAX    = 10'd1000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic [NOW_W-1:0]  now;
    logic              over;
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/nht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nht_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/nht_front.sv @@
// Front end: accepts items, saturates loads, checks limits and slot range, builds commands.
// Depends on nht_pkg.
`default_nettype none

module nht_front
  import nht_pkg::*;
#(
  parameter int NODES = 16
) (
  input  wire logic              start_i,
  input  wire logic              full_i,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [IDX_W-1:0]  node_index_i,
  input  wire logic [NOW_W-1:0]  now_ms_i,
  input  wire logic [LOAD_W-1:0] cpu_load_i,
  input  wire logic [LOAD_W-1:0] mem_load_i,
  input  wire logic [TASK_W-1:0] task_count_i,
  input  wire logic [LOAD_W-1:0] cpu_limit_i,
  input  wire logic [LOAD_W-1:0] mem_limit_i,
  input  wire logic [TASK_W-1:0] task_limit_i,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  logic [LOAD_W-1:0] cpu_sat, mem_sat;

  assign cpu_sat = (cpu_load_i > LOAD_MAX) ? LOAD_MAX : cpu_load_i;
  assign mem_sat = (mem_load_i > LOAD_MAX) ? LOAD_MAX : mem_load_i;

  assign push_o = start_i && !full_i;

  always_comb begin
    cmd_o.kind     = kind_i;
    cmd_o.idx      = node_index_i;
    cmd_o.in_range = (32'(node_index_i) < NODES);
    cmd_o.now      = now_ms_i;
    cmd_o.over     = (cpu_sat > cpu_limit_i) || (mem_sat > mem_limit_i) ||
                     (task_count_i > task_limit_i);
  end

endmodule

`default_nettype wire

@@ hw/rtl/nht_queue.sv @@
// Short command queue between the front end and the table engine.
// Depends on nht_pkg.
`default_nettype none

module nht_queue
  import nht_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CntW = $clog2(QDEPTH + 1);

  cmd_t            ent_q [QDEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = ent_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nht_back.sv @@
// Table engine: valid bits, status/timestamp RAM, per-slot read-modify-write and the sweep.
// Depends on nht_pkg and nht_ram.
`default_nettype none

module nht_back
  import nht_pkg::*;
#(
  parameter int NODES     = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  input  wire cmd_t                 q_cmd_i,
  input  wire logic [TIMEOUT_W-1:0] timeout_i,
  output logic                      q_pop_o,
  output logic                      res_valid_o,
  output logic                      res_ok_o,
  output logic [1:0]                res_status_o,
  output logic                      res_known_o
);

  localparam int IdxSpan = 2 ** IDX_W;
  localparam int Slots   = (NODES < IdxSpan) ? NODES : IdxSpan;
  localparam int Aw      = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int Dw      = 2 + TIME_BITS;
  localparam int Cw      = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

  typedef enum logic [3:0] {
    BK_IDLE  = 4'b0001,
    BK_EXEC  = 4'b0010,
    BK_SW_RD = 4'b0100,
    BK_SW_EX = 4'b1000
  } back_state_e;

  back_state_e          state_q, state_d;
  cmd_t                 cmd_q, cmd_d;
  logic [Aw-1:0]        cnt_q, cnt_d;
  logic [Slots-1:0]     valid_q, valid_d;
  logic                 res_valid_q, res_valid_d;
  logic                 res_ok_q, res_ok_d;
  logic [1:0]           res_status_q, res_status_d;
  logic                 res_known_q, res_known_d;

  logic                 ram_we;
  logic [Aw-1:0]        ram_waddr, ram_raddr, slot;
  logic [Dw-1:0]        ram_wdata, ram_rdata;
  logic [1:0]           rd_status, new_status;
  logic [TIME_BITS-1:0] rd_time, new_time, now_t, age;
  logic                 cur_v, new_v, sw_last;

  nht_ram #(
    .WIDTH(Dw),
    .DEPTH(Slots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_status = ram_rdata[Dw-1 -: 2];
  assign rd_time   = ram_rdata[TIME_BITS-1:0];
  assign now_t     = TIME_BITS'(cmd_q.now);
  assign age       = now_t - rd_time;
  assign slot      = Aw'(cmd_q.idx);
  assign sw_last   = (cnt_q == Aw'(Slots - 1));
  assign cur_v     = cmd_q.in_range && valid_q[slot];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    valid_d      = valid_q;
    q_pop_o      = 1'b0;
    ram_raddr    = cnt_q;
    ram_we       = 1'b0;
    ram_waddr    = slot;
    new_v        = cur_v;
    new_status   = rd_status;
    new_time     = rd_time;
    res_valid_d  = 1'b0;
    res_ok_d     = 1'b0;
    res_status_d = ST_DOWN;
    res_known_d  = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        ram_raddr = Aw'(q_cmd_i.idx);
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          cnt_d   = '0;
          state_d = (q_cmd_i.kind == KIND_SWEEP) ? BK_SW_RD : BK_EXEC;
        end
      end
      BK_EXEC: begin
        case (cmd_q.kind)
          KIND_REG: begin
            if (cmd_q.in_range && !cur_v) begin
              new_v      = 1'b1;
              new_status = ST_IDLE;
              new_time   = now_t;
              ram_we     = 1'b1;
              res_ok_d   = 1'b1;
            end
          end
          KIND_UNREG: begin
            if (cur_v) begin
              new_v    = 1'b0;
              res_ok_d = 1'b1;
            end
          end
          KIND_BEAT: begin
            if (cur_v) begin
              new_time = now_t;
              if (rd_status == ST_DOWN) begin
                new_status = ST_IDLE;
              end
              ram_we   = 1'b1;
              res_ok_d = 1'b1;
            end
          end
          KIND_REPORT: begin
            if (cur_v) begin
              if (cmd_q.over) begin
                new_status = ST_OVER;
              end else if (rd_status == ST_OVER) begin
                new_status = ST_IDLE;
              end
              ram_we   = 1'b1;
              res_ok_d = 1'b1;
            end
          end
          KIND_QUERY: res_ok_d = cur_v;
          default: ;
        endcase
        if (cmd_q.in_range) begin
          valid_d[slot] = new_v;
        end
        res_valid_d  = 1'b1;
        res_known_d  = new_v;
        res_status_d = new_v ? new_status : ST_DOWN;
        state_d      = BK_IDLE;
      end
      BK_SW_RD: begin
        state_d = BK_SW_EX;
      end
      BK_SW_EX: begin
        ram_raddr = cnt_q + 1'b1;
        ram_waddr = cnt_q;
        if (valid_q[cnt_q] && (Cw'(age) > Cw'(timeout_i))) begin
          new_status = ST_DOWN;
          ram_we     = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (sw_last) begin
          res_valid_d  = 1'b1;
          res_ok_d     = 1'b1;
          res_status_d = ST_IDLE;
          res_known_d  = 1'b0;
          state_d      = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign ram_wdata = {new_status, new_time};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    res_ok_q     <= res_ok_d;
    res_status_q <= res_status_d;
    res_known_q  <= res_known_d;
  end

  assign res_valid_o  = res_valid_q;
  assign res_ok_o     = res_ok_q;
  assign res_status_o = res_status_q;
  assign res_known_o  = res_known_q;

  a_no_back_to_back_results : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("results on consecutive cycles");

  a_sweep_covers_all_slots : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SW_EX) && (state_d == BK_IDLE) |-> (cnt_q == Aw'(Slots - 1)))
    else $error("sweep ended early");

  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && (state_q == BK_EXEC) |-> cmd_q.in_range)
    else $error("table write to a slot out of range");

endmodule

`default_nettype wire

@@ hw/rtl/node_health_table_core.sv @@
// When the engine is idle, an accepted item passes through the command queue and the engine's
// command register before the registered result strobe rises. A single-slot item is a read
// then a write of one RAM entry; a sweep steps through all min(NODES,16) slots. A 2-entry command
// queue takes items meanwhile; busy is high while it is full. The receiver cannot stall results.
// Reset clears valid bits and queue, sets config registers to defaults; the RAM is not cleared.
// Depends on nht_pkg, nht_front, nht_queue, nht_back, nht_ram.
`default_nettype none

module node_health_table_core
  import nht_pkg::*;
#(
  parameter int NODES     = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [KIND_W-1:0]    kind_i,
  input  wire logic [IDX_W-1:0]     node_index_i,
  input  wire logic [NOW_W-1:0]     now_ms_i,
  input  wire logic [LOAD_W-1:0]    cpu_load_i,
  input  wire logic [LOAD_W-1:0]    mem_load_i,
  input  wire logic [TASK_W-1:0]    task_count_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output logic                      result_valid_o,
  output logic                      ok_o,
  output logic [1:0]                node_status_o,
  output logic                      known_o
);

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [LOAD_W-1:0]    cpu_limit_q, mem_limit_q;
  logic [TASK_W-1:0]    task_limit_q;

  logic push, full, q_valid, q_pop;
  cmd_t front_cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TIMEOUT_RST;
      cpu_limit_q  <= CPU_RST;
      mem_limit_q  <= MEM_RST;
      task_limit_q <= TASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT: timeout_q    <= cfg_data_i[TIMEOUT_W-1:0];
        CFG_CPU:     cpu_limit_q  <= cfg_data_i[LOAD_W-1:0];
        CFG_MEM:     mem_limit_q  <= cfg_data_i[LOAD_W-1:0];
        CFG_TASK:    task_limit_q <= cfg_data_i[TASK_W-1:0];
        default: ;
      endcase
    end
  end

  nht_front #(
    .NODES(NODES)
  ) u_front (
    .start_i     (start),
    .full_i      (full),
    .kind_i      (kind_i),
    .node_index_i(node_index_i),
    .now_ms_i    (now_ms_i),
    .cpu_load_i  (cpu_load_i),
    .mem_load_i  (mem_load_i),
    .task_count_i(task_count_i),
    .cpu_limit_i (cpu_limit_q),
    .mem_limit_i (mem_limit_q),
    .task_limit_i(task_limit_q),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  nht_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (q_pop),
    .full_o (full),
    .valid_o(q_valid),
    .cmd_o  (q_cmd)
  );

  nht_back #(
    .NODES    (NODES),
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .timeout_i   (timeout_q),
    .q_pop_o     (q_pop),
    .res_valid_o (result_valid_o),
    .res_ok_o    (ok_o),
    .res_status_o(node_status_o),
    .res_known_o (known_o)
  );

  assign busy = full;

endmodule

`default_nettype wire

@@ tb/nht_health_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard for the node health table core: mirrors the slot table and the limits from
// observed items and register writes, predicts every result and checks the strobed outputs.
// Depends on nht_pkg for widths, item codes, status codes and register indexes.
module nht_health_scoreboard
  import nht_pkg::*;
#(
  parameter int NODES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 busy_i,
  input  wire logic [KIND_W-1:0]    kind_i,
  input  wire logic [IDX_W-1:0]     node_index_i,
  input  wire logic [NOW_W-1:0]     now_ms_i,
  input  wire logic [LOAD_W-1:0]    cpu_load_i,
  input  wire logic [LOAD_W-1:0]    mem_load_i,
  input  wire logic [TASK_W-1:0]    task_count_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 result_valid_i,
  input  wire logic                 ok_i,
  input  wire logic [1:0]           node_status_i,
  input  wire logic                 known_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic       ok;
    logic [1:0] status;
    logic       known;
  } health_t;

  logic [NODES-1:0]     slot_live;
  logic [1:0]           slot_state [NODES];
  logic [NOW_W-1:0]     slot_beat  [NODES];
  logic [TIMEOUT_W-1:0] timeout_lim;
  logic [LOAD_W-1:0]    cpu_lim;
  logic [LOAD_W-1:0]    mem_lim;
  logic [TASK_W-1:0]    task_lim;
  health_t              health_due [$];
  health_t              got;
  health_t              want;

  function automatic health_t predict_health(input logic [KIND_W-1:0] kind,
                                             input logic [IDX_W-1:0]  idx,
                                             input logic [NOW_W-1:0]  now,
                                             input logic [LOAD_W-1:0] cpu,
                                             input logic [LOAD_W-1:0] mem,
                                             input logic [TASK_W-1:0] tasks);
    health_t           r;
    logic [NOW_W-1:0]  age;
    logic [LOAD_W-1:0] cpu_s;
    logic [LOAD_W-1:0] mem_s;
    logic              in_table;
    logic              live;
    int                s;
    int                i;
    in_table = int'(idx) < NODES;
    s        = in_table ? int'(idx) : 0;
    live     = in_table && slot_live[s];
    r        = '0;
    if (kind == KIND_SWEEP) begin
      for (i = 0; i < NODES; i++) begin
        if (slot_live[i]) begin
          age = now - slot_beat[i];
          if (age > {1'b0, timeout_lim}) slot_state[i] = ST_DOWN;
        end
      end
      r.ok = 1'b1;
      return r;
    end
    cpu_s = (cpu > LOAD_MAX) ? LOAD_MAX : cpu;
    mem_s = (mem > LOAD_MAX) ? LOAD_MAX : mem;
    case (kind)
      KIND_REG: begin
        if (in_table && !live) begin
          slot_live[s]  = 1'b1;
          slot_state[s] = ST_IDLE;
          slot_beat[s]  = now;
          r.ok          = 1'b1;
        end
      end
      KIND_UNREG: begin
        if (live) begin
          slot_live[s] = 1'b0;
          r.ok         = 1'b1;
        end
      end
      KIND_BEAT: begin
        if (live) begin
          slot_beat[s] = now;
          if (slot_state[s] == ST_DOWN) slot_state[s] = ST_IDLE;
          r.ok = 1'b1;
        end
      end
      KIND_REPORT: begin
        if (live) begin
          if (cpu_s > cpu_lim || mem_s > mem_lim || tasks > task_lim) begin
            slot_state[s] = ST_OVER;
          end else if (slot_state[s] == ST_OVER) begin
            slot_state[s] = ST_IDLE;
          end
          r.ok = 1'b1;
        end
      end
      KIND_QUERY: r.ok = live;
      default: ;
    endcase
    live     = in_table && slot_live[s];
    r.status = live ? slot_state[s] : ST_DOWN;
    r.known  = live;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_live    = '0;
      timeout_lim  = TIMEOUT_RST;
      cpu_lim      = CPU_RST;
      mem_lim      = MEM_RST;
      task_lim     = TASK_RST;
      health_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (result_valid_i) begin
        got = {ok_i, node_status_i, known_i};
        if (health_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 50)
            $display("%0t: unexpected result, none pending: ok=%0b status=%0d known=%0b",
                     $time, got.ok, got.status, got.known);
        end else begin
          want = health_due.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 50)
              $display("%0t: expected ok=%0b st=%0d kn=%0b, got ok=%0b st=%0d kn=%0b",
                       $time, want.ok, want.status, want.known,
                       got.ok, got.status, got.known);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TIMEOUT: timeout_lim = cfg_data_i[TIMEOUT_W-1:0];
          CFG_CPU:     cpu_lim     = cfg_data_i[LOAD_W-1:0];
          CFG_MEM:     mem_lim     = cfg_data_i[LOAD_W-1:0];
          CFG_TASK:    task_lim    = cfg_data_i[TASK_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        health_due.insert(health_due.size(),
                          predict_health(kind_i, node_index_i, now_ms_i,
                                         cpu_load_i, mem_load_i, task_count_i));
      pending_o = health_due.size();
    end
  end

endmodule

@@ tb/node_health_table_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the node health table testbench: clock, reset, register settings and item stimulus.
// Depends on nht_pkg, node_health_table_core and nht_health_scoreboard.
module node_health_table_core_tb;
  import nht_pkg::*;

  localparam int NODES       = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic                 busy;
  logic [KIND_W-1:0]    kind         = '0;
  logic [IDX_W-1:0]     node_index   = '0;
  logic [NOW_W-1:0]     now_ms       = '0;
  logic [LOAD_W-1:0]    cpu_load     = '0;
  logic [LOAD_W-1:0]    mem_load     = '0;
  logic [TASK_W-1:0]    task_count   = '0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 result_valid;
  logic                 ok;
  logic [1:0]           node_status;
  logic                 known;
  int                   fail_count;
  int                   pending;

  int                   cycles       = 0;
  int unsigned          items_sent   = 0;
  int unsigned          settings_run = 1;
  logic                 gappy        = 1'b1;
  logic [NOW_W-1:0]     clock_ms     = '0;
  int unsigned          step_max     = 1000;
  logic [TIMEOUT_W-1:0] timeout_cfg  = TIMEOUT_RST;
  logic [LOAD_W-1:0]    cpu_cfg      = CPU_RST;
  logic [LOAD_W-1:0]    mem_cfg      = MEM_RST;
  logic [TASK_W-1:0]    task_cfg     = TASK_RST;

  node_health_table_core #(
    .NODES    (NODES),
    .TIME_BITS(32)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind),
    .node_index_i  (node_index),
    .now_ms_i      (now_ms),
    .cpu_load_i    (cpu_load),
    .mem_load_i    (mem_load),
    .task_count_i  (task_count),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .result_valid_o(result_valid),
    .ok_o          (ok),
    .node_status_o (node_status),
    .known_o       (known)
  );

  nht_health_scoreboard #(
    .NODES(NODES)
  ) u_scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .kind_i        (kind),
    .node_index_i  (node_index),
    .now_ms_i      (now_ms),
    .cpu_load_i    (cpu_load),
    .mem_load_i    (mem_load),
    .task_count_i  (task_count),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .result_valid_i(result_valid),
    .ok_i          (ok),
    .node_status_i (node_status),
    .known_i       (known),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d results outstanding",
               $time, cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx,
                           input logic [NOW_W-1:0] t, input logic [LOAD_W-1:0] c,
                           input logic [LOAD_W-1:0] m, input logic [TASK_W-1:0] n);
    int unsigned gap;
    gap = gappy ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    kind       <= k;
    node_index <= idx;
    now_ms     <= t;
    cpu_load   <= c;
    mem_load   <= m;
    task_count <= n;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [TIMEOUT_W-1:0] t, input logic [LOAD_W-1:0] c,
                                input logic [LOAD_W-1:0] m, input logic [TASK_W-1:0] n);
    logic [CFG_IDX_W-1:0] regs [4];
    logic [CFG_W-1:0]     vals [4];
    int                   i;
    regs = '{CFG_TIMEOUT, CFG_CPU, CFG_MEM, CFG_TASK};
    vals = '{CFG_W'(t), CFG_W'(c), CFG_W'(m), CFG_W'(n)};
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we      <= 1'b0;
    timeout_cfg = t;
    cpu_cfg     = c;
    mem_cfg     = m;
    task_cfg    = n;
    settings_run++;
  endtask

  task automatic send_random_item();
    logic [KIND_W-1:0] k;
    logic [LOAD_W-1:0] c;
    logic [LOAD_W-1:0] m;
    logic [TASK_W-1:0] n;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)      k = KIND_REG;
    else if (pick < 23) k = KIND_UNREG;
    else if (pick < 48) k = KIND_BEAT;
    else if (pick < 73) k = KIND_REPORT;
    else if (pick < 85) k = KIND_QUERY;
    else if (pick < 95) k = KIND_SWEEP;
    else                k = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, step_max);
    case ($urandom_range(0, 3))
      0: begin
        c = LOAD_W'($urandom);
        m = LOAD_W'($urandom);
        n = TASK_W'($urandom);
      end
      3: begin
        c = (cpu_cfg == '1) ? cpu_cfg : LOAD_W'(cpu_cfg + $urandom_range(0, 1));
        m = (mem_cfg == '1) ? mem_cfg : LOAD_W'(mem_cfg + $urandom_range(0, 1));
        n = (task_cfg == '1) ? task_cfg : TASK_W'(task_cfg + $urandom_range(0, 1));
      end
      default: begin
        c = LOAD_W'($urandom_range(0, cpu_cfg));
        m = LOAD_W'($urandom_range(0, mem_cfg));
        n = TASK_W'($urandom_range(0, task_cfg));
      end
    endcase
    send_item(k, IDX_W'($urandom_range(0, NODES - 1)), clock_ms, c, m, n);
  endtask

  task automatic run_phase(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 64 == 0) gappy = ($urandom_range(0, 2) != 0);
      if (i == count / 2) drain();
      send_random_item();
    end
  endtask

  initial begin
    logic [TIMEOUT_W-1:0] t;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty slots, double register, saturation and equality at the limits
    send_item(KIND_QUERY,  4'd0,  32'd0, 10'd0, 10'd0, 16'd0);
    send_item(KIND_UNREG,  4'd3,  32'd0, 10'd0, 10'd0, 16'd0);
    send_item(KIND_BEAT,   4'd5,  32'd0, 10'd0, 10'd0, 16'd0);
    send_item(KIND_REPORT, 4'd7,  32'd0, 10'd1023, 10'd1023, 16'hFFFF);
    send_item(KIND_REG,    4'd0,  32'd0, 10'd0, 10'd0, 16'd0);
    send_item(KIND_REG,    4'd0,  32'd5, 10'd0, 10'd0, 16'd0);
    send_item(KIND_REG,    4'd15, 32'hFFFF_FFFF, 10'd0, 10'd0, 16'd0);
    send_item(KIND_REPORT, 4'd0,  32'd1, 10'd1023, 10'd0, 16'd0);
    send_item(KIND_REPORT, 4'd0,  32'd1, 10'd800, 10'd800, 16'd100);
    send_item(KIND_REPORT, 4'd0,  32'd1, 10'd0, 10'd801, 16'd0);
    send_item(KIND_REPORT, 4'd0,  32'd1, 10'd0, 10'd0, 16'hFFFF);
    send_item(KIND_REPORT, 4'd0,  32'd1, 10'd0, 10'd0, 16'd0);
    // sweep across the wrap: slot 15 ages out, slot 0 sits exactly at the timeout
    send_item(KIND_SWEEP,  4'd0,  32'd30000, 10'd0, 10'd0, 16'd0);
    send_item(KIND_QUERY,  4'd15, 32'd30000, 10'd0, 10'd0, 16'd0);
    send_item(KIND_REPORT, 4'd15, 32'd30000, 10'd0, 10'd0, 16'd0);
    send_item(KIND_REPORT, 4'd15, 32'd30000, 10'd1000, 10'd0, 16'd0);
    send_item(KIND_SWEEP,  4'd9,  32'd30001, 10'd0, 10'd0, 16'd0);
    send_item(KIND_QUERY,  4'd0,  32'd30001, 10'd0, 10'd0, 16'd0);
    send_item(KIND_BEAT,   4'd15, 32'd30001, 10'd0, 10'd0, 16'd0);
    send_item(KIND_UNREG,  4'd15, 32'd30001, 10'd0, 10'd0, 16'd0);
    send_item(KIND_QUERY,  4'd15, 32'd30001, 10'd0, 10'd0, 16'd0);
    send_item(KIND_SPARE_LO, 4'd0,  32'd30001, 10'd0, 10'd0, 16'd0);
    send_item(KIND_SPARE_HI, 4'd15, 32'd30001, 10'd0, 10'd0, 16'd0);
    clock_ms = 32'd30001;

    drain();
    apply_settings('0, '0, '0, '0);
    step_max = 40;
    run_phase(150);

    drain();
    clock_ms = 32'hFFFF_F000;
    apply_settings('1, LOAD_MAX, LOAD_MAX, '1);
    step_max = 2000;
    run_phase(150);

    drain();
    apply_settings(TIMEOUT_RST, CPU_RST, MEM_RST, TASK_RST);
    step_max = 3000;
    run_phase(250);

    repeat (3) begin
      drain();
      t = TIMEOUT_W'($urandom_range(1, 20000));
      apply_settings(t, LOAD_W'($urandom_range(0, 1000)), LOAD_W'($urandom_range(0, 1000)),
                     TASK_W'($urandom_range(0, 65535)));
      step_max = t / 8 + 1;
      run_phase(130);
    end

    drain();
    repeat (30) @(negedge clk);
    $display("Ran %0d items under %0d register settings: all operations, spare kind codes,",
             items_sent, settings_run);
    $display("empty and occupied slots, saturated loads, limit extremes and wrapped sweeps.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ node_health_table_core.f @@
hw/rtl/nht_pkg.sv
hw/rtl/nht_ram.sv
hw/rtl/nht_front.sv
hw/rtl/nht_queue.sv
hw/rtl/nht_back.sv
hw/rtl/node_health_table_core.sv
tb/nht_health_scoreboard.sv
tb/node_health_table_core_tb.sv
